// ===== sv/tdt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tdt_pkg;

	localparam int ADDR_W = 64;
	localparam int TASK_ID_W = 6;
	localparam int PATTERN_W = 64;

	localparam int DEFAULT_TABLE_ENTRIES = 64;
	localparam int DEFAULT_TASK_SLOTS = 64;

	// Word width of one table entry: valid, address, writer flag, writer id, reader mask.
	localparam int DEFAULT_ENTRY_W = 1 + ADDR_W + 1 + TASK_ID_W + DEFAULT_TASK_SLOTS;

	localparam logic OP_CHECK = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE,
		ST_RESULT
	} state_t;

	typedef struct packed {
		logic operation;
		logic [TASK_ID_W-1:0] task_id;
		logic [ADDR_W-1:0] dep_address;
		logic dir_in;
		logic dir_out;
		logic last_dep;
	} in_item_t;

	typedef struct packed {
		logic [PATTERN_W-1:0] dep_pattern;
		logic table_full;
		logic result_last;
	} out_item_t;

endpackage

`default_nettype wire

// ===== sv/task_dependence_tracker_top.sv =====
// Task dependence tracker.
// in_item carries one dependence of a new task (check) or of a finished task
// (release); out_item returns one result per input transaction, in order:
// the running dependence pattern (zero for a release), a table-full flag and a copy of last_dep.
// Both channels use valid/ready; a transaction completes when both are high.
// After reset the block sweeps the address table once to clear every entry,
// with in_ready low; then it waits for input.
// Each item with a task id inside the task slots walks the table one entry per
// cycle through a single address comparator, stopping at the first match, then
// does at most one read-modify-write; an item with a task id outside the task
// slots skips the walk. A new item is taken no earlier than the cycle after the
// previous result is loaded into the output register, so the block never works
// on two items at once.
// While the receiver stalls, the result waits in the output register and the
// block can still accept and work on the next item; it holds that item's
// result until the register frees up.
`timescale 1ns / 1ps
`default_nettype none

module task_dependence_tracker_top #(
	parameter int TABLE_ENTRIES = tdt_pkg::DEFAULT_TABLE_ENTRIES,
	parameter int TASK_SLOTS = tdt_pkg::DEFAULT_TASK_SLOTS
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire tdt_pkg::in_item_t in_item,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output tdt_pkg::out_item_t     out_item
);

	import tdt_pkg::*;

	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

	typedef struct packed {
		logic valid;
		logic [ADDR_W-1:0] address;
		logic writer_present;
		logic [TASK_ID_W-1:0] writer_task;
		logic [TASK_SLOTS-1:0] reader_mask;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	state_t state_q, state_d;
	in_item_t item_q;
	logic task_ok_q;
	logic [IDX_W-1:0] scan_idx_q;
	logic [IDX_W-1:0] cmp_idx_s1;
	logic cmp_vld_s1;
	logic hit_q;
	logic free_found_q;
	logic [IDX_W-1:0] hit_idx_q;
	logic [IDX_W-1:0] free_idx_q;
	entry_t ent_q;
	logic [TASK_SLOTS-1:0] acc_q;
	logic full_q;
	logic out_valid_q;
	out_item_t out_q;

	logic mem_rd_en;
	logic mem_wr_en;
	logic [IDX_W-1:0] mem_wr_addr;
	entry_t mem_wr_data;
	logic [ENTRY_W-1:0] mem_rd_data;
	entry_t rd_entry;

	logic accept;
	logic in_task_ok;
	logic res_load;
	logic match;
	logic scan_end;
	logic [TASK_SLOTS-1:0] task_bit;
	logic [TASK_SLOTS-1:0] writer_bit;

	entry_t upd_entry;
	logic upd_we;
	logic [IDX_W-1:0] upd_idx;
	logic [TASK_SLOTS-1:0] upd_add;
	logic upd_full;

	tdt_table #(
		.DEPTH(TABLE_ENTRIES),
		.WIDTH(ENTRY_W)
	) u_table (
		.clk    (clk),
		.rd_en  (mem_rd_en),
		.rd_addr(scan_idx_q),
		.rd_data(mem_rd_data),
		.wr_en  (mem_wr_en),
		.wr_addr(mem_wr_addr),
		.wr_data(mem_wr_data)
	);

	assign rd_entry = mem_rd_data;
	assign accept = in_valid && in_ready;
	assign in_task_ok = int'(in_item.task_id) < TASK_SLOTS;

	// A task id at or beyond the slot count shifts the bit out, giving zero.
	assign task_bit = TASK_SLOTS'(1) << item_q.task_id;
	assign writer_bit = TASK_SLOTS'(1) << ent_q.writer_task;

	// The shared comparator sees the entry read in the previous cycle.
	assign match = cmp_vld_s1 && rd_entry.valid && (rd_entry.address == item_q.dep_address);
	assign scan_end = cmp_vld_s1 && (cmp_idx_s1 == LAST_IDX);

	always_comb begin
		upd_entry = ent_q;
		upd_we = 1'b0;
		upd_idx = hit_idx_q;
		upd_add = '0;
		upd_full = 1'b0;
		if (task_ok_q) begin
			if (item_q.operation == OP_CHECK) begin
				if (hit_q) begin
					upd_we = 1'b1;
					if (item_q.dir_out) begin
						if (ent_q.reader_mask != '0) begin
							upd_add = ent_q.reader_mask;
						end else if (ent_q.writer_present) begin
							upd_add = writer_bit;
						end
						upd_entry.writer_present = 1'b1;
						upd_entry.writer_task = item_q.task_id;
						upd_entry.reader_mask = '0;
					end else begin
						if (ent_q.writer_present) begin
							upd_add = writer_bit;
						end
						upd_entry.reader_mask = ent_q.reader_mask | task_bit;
					end
				end else if (free_found_q) begin
					upd_we = 1'b1;
					upd_idx = free_idx_q;
					upd_entry.valid = 1'b1;
					upd_entry.address = item_q.dep_address;
					if (item_q.dir_out) begin
						upd_entry.writer_present = 1'b1;
						upd_entry.writer_task = item_q.task_id;
						upd_entry.reader_mask = '0;
					end else begin
						upd_entry.writer_present = 1'b0;
						upd_entry.writer_task = '0;
						upd_entry.reader_mask = task_bit;
					end
				end else begin
					upd_full = 1'b1;
				end
			end else if (hit_q) begin
				upd_we = 1'b1;
				if (item_q.dir_out) begin
					if (ent_q.writer_present && (ent_q.writer_task == item_q.task_id)) begin
						upd_entry.writer_present = 1'b0;
					end
				end else begin
					upd_entry.reader_mask = ent_q.reader_mask & ~task_bit;
				end
				// An entry with neither a writer nor readers goes back to the free pool.
				upd_entry.valid = upd_entry.writer_present || (upd_entry.reader_mask != '0);
			end
		end
	end

	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		mem_rd_en = 1'b0;
		mem_wr_en = 1'b0;
		mem_wr_addr = scan_idx_q;
		mem_wr_data = '0;
		res_load = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				mem_wr_en = 1'b1;
				if (scan_idx_q == LAST_IDX) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = in_task_ok ? ST_SCAN : ST_UPDATE;
				end
			end
			ST_SCAN: begin
				mem_rd_en = (scan_idx_q <= LAST_IDX);
				if (match || scan_end) begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				mem_wr_en = upd_we;
				mem_wr_addr = upd_idx;
				mem_wr_data = upd_entry;
				state_d = ST_RESULT;
			end
			ST_RESULT: begin
				if (!out_valid_q || out_ready) begin
					res_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_idx_q <= '0;
			cmp_vld_s1 <= 1'b0;
			hit_q <= 1'b0;
			free_found_q <= 1'b0;
			acc_q <= '0;
			full_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			cmp_vld_s1 <= mem_rd_en;
			if (accept) begin
				scan_idx_q <= '0;
				hit_q <= 1'b0;
				free_found_q <= 1'b0;
			end else if (state_q == ST_CLEAR || state_q == ST_SCAN) begin
				scan_idx_q <= scan_idx_q + IDX_W'(1);
			end
			if (state_q == ST_SCAN) begin
				if (match && !hit_q) begin
					hit_q <= 1'b1;
				end
				if (cmp_vld_s1 && !rd_entry.valid && !free_found_q) begin
					free_found_q <= 1'b1;
				end
			end
			if (state_q == ST_UPDATE) begin
				acc_q <= acc_q | upd_add;
				full_q <= upd_full;
			end
			if (res_load) begin
				out_valid_q <= 1'b1;
				if (item_q.operation == OP_CHECK && item_q.last_dep) begin
					acc_q <= '0;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		cmp_idx_s1 <= scan_idx_q;
		if (accept) begin
			item_q <= in_item;
			task_ok_q <= in_task_ok;
		end
		if (state_q == ST_SCAN) begin
			if (match && !hit_q) begin
				hit_idx_q <= cmp_idx_s1;
				ent_q <= rd_entry;
			end
			if (cmp_vld_s1 && !rd_entry.valid && !free_found_q) begin
				free_idx_q <= cmp_idx_s1;
			end
		end
		if (res_load) begin
			if (item_q.operation == OP_RELEASE) begin
				out_q.dep_pattern <= '0;
				out_q.table_full <= 1'b0;
			end else begin
				out_q.dep_pattern <= PATTERN_W'(acc_q);
				out_q.table_full <= full_q;
			end
			out_q.result_last <= item_q.last_dep;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item = out_q;

`ifndef SYNTH
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while an item was still in progress");

	a_result_from_sequencer: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_RESULT))
		else $error("result appeared without the sequencer finishing an item");

	a_no_write_during_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> !mem_wr_en)
		else $error("table written while the lookup walk was running");
`endif

endmodule

`default_nettype wire

// ===== sv/tdt_table.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tdt_table #(
	parameter int DEPTH = tdt_pkg::DEFAULT_TABLE_ENTRIES,
	parameter int WIDTH = tdt_pkg::DEFAULT_ENTRY_W
) (
	input  wire logic                     clk,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== test/tdt_result_checker.sv =====
`timescale 1ns / 1ps

module tdt_result_checker #(
	parameter int TABLE_ENTRIES = tdt_pkg::DEFAULT_TABLE_ENTRIES,
	parameter int TASK_SLOTS = tdt_pkg::DEFAULT_TASK_SLOTS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  tdt_pkg::in_item_t  in_item,
	input  logic               out_valid,
	input  logic               out_ready,
	input  tdt_pkg::out_item_t out_item,
	input  logic               end_of_test,
	output int                 mismatch_count
);
	import tdt_pkg::*;

	localparam logic [PATTERN_W-1:0] SLOT_MASK = {PATTERN_W{1'b1}} >> (PATTERN_W - TASK_SLOTS);

	logic                 entry_used [TABLE_ENTRIES];
	logic [ADDR_W-1:0]    entry_key [TABLE_ENTRIES];
	logic                 has_writer [TABLE_ENTRIES];
	logic [TASK_ID_W-1:0] writer_id [TABLE_ENTRIES];
	logic [PATTERN_W-1:0] readers [TABLE_ENTRIES];
	logic [PATTERN_W-1:0] running_pattern;
	out_item_t            pending_results [$];
	int                   fail_total = 0;

	assign mismatch_count = fail_total;

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("%0t tdt check: %s, got %h, expected %h", $time, what, got, want);
		fail_total++;
	endtask

	function automatic logic [PATTERN_W-1:0] slot_bit(logic [TASK_ID_W-1:0] id);
		return (PATTERN_W'(1) << id) & SLOT_MASK;
	endfunction

	// Applies one transaction to the shadow table and returns the result it must produce.
	function automatic out_item_t track_dependence(in_item_t it);
		out_item_t res;
		int hit;
		int spare;
		logic [PATTERN_W-1:0] own;
		hit = -1;
		spare = -1;
		own = slot_bit(it.task_id);
		res = '0;
		res.result_last = it.last_dep;
		if (it.task_id < TASK_SLOTS) begin
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				if (hit < 0 && entry_used[i] && entry_key[i] == it.dep_address)
					hit = i;
				if (spare < 0 && !entry_used[i])
					spare = i;
			end
		end
		if (it.operation == OP_RELEASE) begin
			if (hit >= 0) begin
				if (it.dir_out) begin
					if (has_writer[hit] && writer_id[hit] == it.task_id)
						has_writer[hit] = 1'b0;
				end else begin
					readers[hit] &= ~own;
				end
				if (!has_writer[hit] && readers[hit] == '0)
					entry_used[hit] = 1'b0;
			end
			return res;
		end
		if (it.task_id < TASK_SLOTS) begin
			if (hit >= 0) begin
				if (it.dir_out) begin
					// A writer waits on all readers, or on the previous writer when none.
					if (readers[hit] != '0)
						running_pattern |= readers[hit];
					else if (has_writer[hit])
						running_pattern |= slot_bit(writer_id[hit]);
					has_writer[hit] = 1'b1;
					writer_id[hit] = it.task_id;
					readers[hit] = '0;
				end else begin
					if (has_writer[hit])
						running_pattern |= slot_bit(writer_id[hit]);
					readers[hit] |= own;
				end
			end else if (spare < 0) begin
				res.table_full = 1'b1;
			end else begin
				entry_used[spare] = 1'b1;
				entry_key[spare] = it.dep_address;
				has_writer[spare] = it.dir_out;
				writer_id[spare] = it.dir_out ? it.task_id : '0;
				readers[spare] = it.dir_out ? '0 : own;
			end
		end
		res.dep_pattern = running_pattern;
		if (it.last_dep)
			running_pattern = '0;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			for (int i = 0; i < TABLE_ENTRIES; i++)
				entry_used[i] = 1'b0;
			running_pattern = '0;
			pending_results.delete();
		end else begin
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					report_mismatch("result transaction with nothing expected",
						out_item.dep_pattern, '0);
				end else begin
					want = pending_results.pop_front();
					if (out_item.dep_pattern !== want.dep_pattern)
						report_mismatch("dep_pattern", out_item.dep_pattern, want.dep_pattern);
					if (out_item.table_full !== want.table_full)
						report_mismatch("table_full", out_item.table_full, want.table_full);
					if (out_item.result_last !== want.result_last)
						report_mismatch("result_last", out_item.result_last, want.result_last);
				end
			end
			if (in_valid && in_ready)
				pending_results.push_back(track_dependence(in_item));
		end
	end

	always @(posedge end_of_test) begin
		out_item_t missing;
		while (pending_results.size() != 0) begin
			missing = pending_results.pop_front();
			report_mismatch("expected result never arrived", '0, missing.dep_pattern);
		end
	end

endmodule

// ===== test/task_dependence_tracker_top_test.sv =====
`timescale 1ns / 1ps

module task_dependence_tracker_top_test;
	import tdt_pkg::*;

	localparam int TABLE_ENTRIES = DEFAULT_TABLE_ENTRIES;
	localparam int TASK_SLOTS = DEFAULT_TASK_SLOTS;
	localparam int POOL_SIZE = 12;
	localparam int REGULAR_ITEMS = 140;
	localparam int RX_HOLD = 400;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct packed {
		logic [TASK_ID_W-1:0] task_id;
		logic [ADDR_W-1:0]    addr;
		logic                 is_writer;
	} dep_rec_t;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_item_t  in_item;
	logic      out_valid;
	logic      out_ready;
	out_item_t out_item;
	logic      end_of_test;
	int        mismatch_count;

	int   send_idle = 28;
	int   recv_idle = 71;
	logic stall_request = 1'b0;
	int   n_in = 0;
	int   n_out = 0;
	int   quiet_cycles = 0;

	logic [ADDR_W-1:0] addr_pool [POOL_SIZE];
	dep_rec_t          live_deps [$];

	task_dependence_tracker_top #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.TASK_SLOTS(TASK_SLOTS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item(out_item)
	);

	tdt_result_checker #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.TASK_SLOTS(TASK_SLOTS)
	) i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item(out_item),
		.end_of_test(end_of_test),
		.mismatch_count(mismatch_count)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				n_in++;
			if (out_valid && out_ready)
				n_out++;
		end
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("[task_dependence_tracker_top] ERROR");
			$finish;
		end
	end

	// Receiver: random backpressure, with one long hold-off on request.
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall_request) begin
				out_ready <= 1'b0;
				repeat (RX_HOLD) @(negedge clk);
				stall_request = 1'b0;
			end
			out_ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	// Called at a falling edge; returns at the falling edge after the transaction.
	task automatic offer(logic op, logic [TASK_ID_W-1:0] id, logic [ADDR_W-1:0] a,
			logic din, logic dout, logic last);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_item <= '{operation: op, task_id: id, dep_address: a, dir_in: din,
			dir_out: dout, last_dep: last};
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
	endtask

	task automatic retire_random();
		int idx;
		dep_rec_t r;
		idx = $urandom_range(live_deps.size() - 1);
		r = live_deps[idx];
		live_deps.delete(idx);
		// Now and then release with the wrong direction.
		offer(OP_RELEASE, r.task_id, r.addr, $urandom_range(1),
			r.is_writer ^ ($urandom_range(19) == 0), $urandom_range(1));
	endtask

	task automatic retire_all();
		while (live_deps.size() != 0)
			retire_random();
	endtask

	// One new task with a short dependence list, sometimes interleaved with releases.
	task automatic issue_task_list();
		int n;
		logic [TASK_ID_W-1:0] id;
		logic [ADDR_W-1:0] a;
		logic dout;
		logic drop_last;
		n = $urandom_range(1, 4);
		id = $urandom_range(TASK_SLOTS - 1);
		drop_last = ($urandom_range(9) == 0);
		for (int k = 0; k < n; k++) begin
			if (k > 0 && live_deps.size() != 0 && $urandom_range(6) == 0)
				retire_random();
			a = addr_pool[$urandom_range(POOL_SIZE - 1)];
			dout = $urandom_range(1);
			offer(OP_CHECK, id, a, $urandom_range(1), dout, (k == n - 1) && !drop_last);
			live_deps.push_back('{id, a, dout});
		end
	endtask

	// More distinct addresses than the table holds, so the last inserts get dropped.
	task automatic fill_table();
		logic [ADDR_W-1:0] base;
		logic [TASK_ID_W-1:0] id;
		logic dout;
		base = {$urandom, $urandom};
		for (int k = 0; k < TABLE_ENTRIES + 2; k++) begin
			id = $urandom_range(TASK_SLOTS - 1);
			dout = $urandom_range(1);
			offer(OP_CHECK, id, base + k, $urandom_range(1), dout, $urandom_range(1));
			live_deps.push_back('{id, base + k, dout});
		end
	endtask

	task automatic wait_for_drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (n_out != n_in)
			@(negedge clk);
	endtask

	initial begin
		logic [ADDR_W-1:0] a_addr;
		logic [ADDR_W-1:0] b_addr;
		logic [ADDR_W-1:0] ones;
		logic [ADDR_W-1:0] noise_addr;
		logic [TASK_ID_W-1:0] noise_id;
		logic noise_op;
		logic noise_dout;
		int pick;
		int phase_base;

		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		end_of_test = 1'b0;
		addr_pool[0] = '0;
		addr_pool[1] = '1;
		for (int i = 2; i < POOL_SIZE; i++)
			addr_pool[i] = {$urandom, $urandom};
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		a_addr = 64'h0000_0000_0000_1000;
		b_addr = 64'h0000_0000_0000_2000;
		ones = '1;

		for (int ph = 0; ph < 3; ph++) begin
			send_idle = (ph == 0) ? 28 : (ph == 1) ? 71 : 0;
			recv_idle = (ph == 0) ? 71 : (ph == 1) ? 28 : 0;

			if (ph == 0) begin
				offer(OP_CHECK, 1, a_addr, 1'b0, 1'b1, 1'b1);
				offer(OP_CHECK, 2, a_addr, 1'b1, 1'b0, 1'b0);
				// Release of an address never inserted, in the middle of a task's list.
				offer(OP_RELEASE, 7, 64'hDEAD_BEEF_0000_0040, 1'b1, 1'b0, 1'b0);
				offer(OP_CHECK, 2, b_addr, 1'b1, 1'b0, 1'b1);
				offer(OP_CHECK, 3, a_addr, 1'b1, 1'b0, 1'b1);
				offer(OP_CHECK, 4, a_addr, 1'b1, 1'b1, 1'b1);
				// Task 1 is no longer the writer of this address.
				offer(OP_RELEASE, 1, a_addr, 1'b0, 1'b1, 1'b1);
				offer(OP_CHECK, 63, ones, 1'b0, 1'b1, 1'b0);
				offer(OP_CHECK, 0, ones, 1'b1, 1'b0, 1'b1);
				offer(OP_CHECK, 0, '0, 1'b0, 1'b1, 1'b0);
				offer(OP_CHECK, 63, '0, 1'b1, 1'b1, 1'b1);
				offer(OP_RELEASE, 4, a_addr, 1'b0, 1'b1, 1'b0);
				offer(OP_RELEASE, 2, b_addr, 1'b1, 1'b0, 1'b1);
				offer(OP_CHECK, 5, a_addr, 1'b1, 1'b0, 1'b1);
				offer(OP_RELEASE, 5, a_addr, 1'b1, 1'b0, 1'b0);
				offer(OP_RELEASE, 63, '0, 1'b0, 1'b1, 1'b1);
				offer(OP_RELEASE, 0, ones, 1'b1, 1'b0, 1'b0);
				offer(OP_RELEASE, 63, ones, 1'b0, 1'b1, 1'b1);
				// The sender keeps offering while the receiver is held off.
				stall_request = 1'b1;
			end

			phase_base = n_in;
			while (n_in - phase_base < REGULAR_ITEMS) begin
				pick = $urandom_range(99);
				if (pick < 55) begin
					issue_task_list();
				end else if (pick < 85 && live_deps.size() != 0) begin
					retire_random();
				end else begin
					noise_op = $urandom_range(1);
					noise_id = $urandom_range(TASK_SLOTS - 1);
					noise_dout = $urandom_range(1);
					noise_addr = $urandom_range(1) ? addr_pool[$urandom_range(POOL_SIZE - 1)]
						: {$urandom, $urandom};
					offer(noise_op, noise_id, noise_addr, $urandom_range(1), noise_dout,
						$urandom_range(1));
					if (noise_op == OP_CHECK)
						live_deps.push_back('{noise_id, noise_addr, noise_dout});
				end
				while (live_deps.size() > 24)
					retire_random();
			end

			retire_all();
			wait_for_drain();
			fill_table();
			retire_all();
			wait_for_drain();
		end

		repeat (TABLE_ENTRIES + 10) @(negedge clk);
		end_of_test = 1'b1;
		@(negedge clk);
		if (mismatch_count == 0)
			$display("[task_dependence_tracker_top] OK");
		else
			$display("[task_dependence_tracker_top] ERROR");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/tdt_pkg.sv
sv/tdt_table.sv
sv/task_dependence_tracker_top.sv
test/tdt_result_checker.sv
test/task_dependence_tracker_top_test.sv
